### rtl/celr_pkg.sv
// ----------------------------------------------------------------------------
// celr_pkg
// Shared types and constants for the client endpoint learning router.
// ----------------------------------------------------------------------------
package celr_pkg;

   localparam int DEFAULT_RETIRED_DEPTH = 16;

   localparam int ADDR_W     = 32;
   localparam int PORT_W     = 16;
   localparam int ENDPOINT_W = ADDR_W + PORT_W;
   localparam int TIME_W     = 32;
   localparam int REBIND_W   = 16;
   localparam int STATE_W    = 24;
   localparam int ROUTE_W    = 2;
   localparam int COUNT_W    = 5;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [REBIND_W-1:0] REBIND_RESET = REBIND_W'(500);
   localparam logic [STATE_W-1:0]  STATE_RESET  = STATE_W'(30000);

   // register index within the csr map (byte address / 4)
   localparam logic [1:0] REG_TARGET_ADDR = 2'd0;
   localparam logic [1:0] REG_TARGET_PORT = 2'd1;
   localparam logic [1:0] REG_REBIND_IDLE = 2'd2;
   localparam logic [1:0] REG_STATE_IDLE  = 2'd3;

   localparam logic [ROUTE_W-1:0] ROUTE_IGNORE   = 2'd0;
   localparam logic [ROUTE_W-1:0] ROUTE_TO_HOST  = 2'd1;
   localparam logic [ROUTE_W-1:0] ROUTE_TO_CLIENT = 2'd2;

   localparam logic MODE_PACKET = 1'b0;
   localparam logic MODE_TICK   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PUSH,
      ST_RESP
   } state_type;

endpackage

### rtl/celr_ram.sv
// ----------------------------------------------------------------------------
// celr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module celr_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/client_endpoint_learning_router.sv
// Packet word: IDLE captures it, SEARCH walks up to N retired entries, DECIDE,
//   then, when the old client is retired, SHIFT_RD/SHIFT_WR when the list
//   must shift and PUSH, then RESP; one RAM read port walks the list.
// Tick word: IDLE, DECIDE, RESP. One word in flight; results may wait on rsp.
// Reset (synchronous): no client, retired count 0, registers to defaults;
//   list RAM contents are not cleared and are only read below the count.
// ----------------------------------------------------------------------------
// client_endpoint_learning_router
// Learns one client endpoint, routes packets host/client, keeps a FIFO of
// retired endpoints with rebind hold-off and idle expiry.
// ----------------------------------------------------------------------------
module client_endpoint_learning_router #(
   parameter int RETIRED_DEPTH = celr_pkg::DEFAULT_RETIRED_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_mode,
   input  logic [celr_pkg::ADDR_W-1:0]      req_src_addr,
   input  logic [celr_pkg::PORT_W-1:0]      req_src_port,
   input  logic [celr_pkg::TIME_W-1:0]      req_now_ms,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [celr_pkg::ROUTE_W-1:0]     rsp_route,
   output logic                             rsp_expired,
   output logic                             rsp_from_retired,
   output logic                             rsp_client_changed,
   output logic                             rsp_client_valid,
   output logic [celr_pkg::ADDR_W-1:0]      rsp_client_addr,
   output logic [celr_pkg::PORT_W-1:0]      rsp_client_port,
   output logic [celr_pkg::COUNT_W-1:0]     rsp_retired_count,

   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [celr_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [celr_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [celr_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                             csr_pready
);

   localparam int AW = (RETIRED_DEPTH > 1) ? $clog2(RETIRED_DEPTH) : 1;
   localparam int CW = $clog2(RETIRED_DEPTH + 1);
   localparam int EW = celr_pkg::ENDPOINT_W;

   // ---------------- csr ----------------
   logic [celr_pkg::ADDR_W-1:0]   target_addr_ff;
   logic [celr_pkg::PORT_W-1:0]   target_port_ff;
   logic [celr_pkg::REBIND_W-1:0] rebind_ff;
   logic [celr_pkg::STATE_W-1:0]  state_idle_ff;
   logic                          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_addr_ff <= '0;
         target_port_ff <= '0;
         rebind_ff      <= celr_pkg::REBIND_RESET;
         state_idle_ff  <= celr_pkg::STATE_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            celr_pkg::REG_TARGET_ADDR: target_addr_ff <= csr_pwdata;
            celr_pkg::REG_TARGET_PORT: target_port_ff <= csr_pwdata[celr_pkg::PORT_W-1:0];
            celr_pkg::REG_REBIND_IDLE: rebind_ff <= csr_pwdata[celr_pkg::REBIND_W-1:0];
            celr_pkg::REG_STATE_IDLE:  state_idle_ff <= csr_pwdata[celr_pkg::STATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         celr_pkg::REG_TARGET_ADDR: csr_prdata = target_addr_ff;
         celr_pkg::REG_TARGET_PORT: csr_prdata = celr_pkg::CSR_DW'(target_port_ff);
         celr_pkg::REG_REBIND_IDLE: csr_prdata = celr_pkg::CSR_DW'(rebind_ff);
         celr_pkg::REG_STATE_IDLE:  csr_prdata = celr_pkg::CSR_DW'(state_idle_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // ---------------- retired list memory ----------------
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [EW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [EW-1:0] ram_rd_data;

   celr_ram #(
      .WIDTH (EW),
      .DEPTH (RETIRED_DEPTH),
      .AW    (AW)
   ) u_retired_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------- sequencer state ----------------
   celr_pkg::state_type state_ff, state_in;

   // captured request word
   logic                         mode_ff, mode_in;
   logic [celr_pkg::ADDR_W-1:0]  src_addr_ff, src_addr_in;
   logic [celr_pkg::PORT_W-1:0]  src_port_ff, src_port_in;
   logic [celr_pkg::TIME_W-1:0]  now_ff, now_in;

   // endpoint state
   logic                         have_ff, have_in;
   logic [celr_pkg::ADDR_W-1:0]  cur_addr_ff, cur_addr_in;
   logic [celr_pkg::PORT_W-1:0]  cur_port_ff, cur_port_in;
   logic [celr_pkg::TIME_W-1:0]  seen_ms_ff, seen_ms_in;
   logic [CW-1:0]                used_ff, used_in;

   // walk control
   logic [CW-1:0]                idx_ff, idx_in;
   logic                         pend_ff, pend_in;
   logic [AW-1:0]                chk_idx_ff, chk_idx_in;
   logic [AW-1:0]                k_ff, k_in;
   logic                         found_ff, found_in;
   logic [EW-1:0]                old_ff, old_in;

   // result flags
   logic [celr_pkg::ROUTE_W-1:0] route_ff, route_in;
   logic                         expired_ff, expired_in;
   logic                         changed_ff, changed_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [celr_pkg::ROUTE_W-1:0] rsp_route_ff, rsp_route_in;
   logic                         rsp_expired_ff, rsp_expired_in;
   logic                         rsp_was_ret_ff, rsp_was_ret_in;
   logic                         rsp_changed_ff, rsp_changed_in;
   logic                         rsp_cvalid_ff, rsp_cvalid_in;
   logic [celr_pkg::ADDR_W-1:0]  rsp_caddr_ff, rsp_caddr_in;
   logic [celr_pkg::PORT_W-1:0]  rsp_cport_ff, rsp_cport_in;
   logic [celr_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [celr_pkg::TIME_W-1:0]  idle_time;
   logic                         rebind_ok;
   logic                         state_expired;
   logic                         entry_hit;
   logic                         from_target;
   logic                         from_client;
   logic [CW-1:0]                k_next;

   assign idle_time     = now_ff - seen_ms_ff;
   assign rebind_ok     = idle_time >= celr_pkg::TIME_W'(rebind_ff);
   assign state_expired = idle_time >= celr_pkg::TIME_W'(state_idle_ff);
   assign entry_hit     = pend_ff && (ram_rd_data == {src_addr_ff, src_port_ff});
   assign from_target   = (src_addr_ff == target_addr_ff) && (src_port_ff == target_port_ff);
   assign from_client   = (src_addr_ff == cur_addr_ff) && (src_port_ff == cur_port_ff);
   assign k_next        = CW'(k_ff) + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= celr_pkg::ST_IDLE;
         have_ff      <= 1'b0;
         cur_addr_ff  <= '0;
         cur_port_ff  <= '0;
         seen_ms_ff   <= '0;
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_ff      <= have_in;
         cur_addr_ff  <= cur_addr_in;
         cur_port_ff  <= cur_port_in;
         seen_ms_ff   <= seen_ms_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      src_addr_ff    <= src_addr_in;
      src_port_ff    <= src_port_in;
      now_ff         <= now_in;
      idx_ff         <= idx_in;
      chk_idx_ff     <= chk_idx_in;
      k_ff           <= k_in;
      found_ff       <= found_in;
      old_ff         <= old_in;
      route_ff       <= route_in;
      expired_ff     <= expired_in;
      changed_ff     <= changed_in;
      rsp_route_ff   <= rsp_route_in;
      rsp_expired_ff <= rsp_expired_in;
      rsp_was_ret_ff <= rsp_was_ret_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_cvalid_ff  <= rsp_cvalid_in;
      rsp_caddr_ff   <= rsp_caddr_in;
      rsp_cport_ff   <= rsp_cport_in;
      rsp_count_ff   <= rsp_count_in;
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      src_addr_in    = src_addr_ff;
      src_port_in    = src_port_ff;
      now_in         = now_ff;
      have_in        = have_ff;
      cur_addr_in    = cur_addr_ff;
      cur_port_in    = cur_port_ff;
      seen_ms_in     = seen_ms_ff;
      used_in        = used_ff;
      idx_in         = idx_ff;
      pend_in        = 1'b0;
      chk_idx_in     = chk_idx_ff;
      k_in           = k_ff;
      found_in       = found_ff;
      old_in         = old_ff;
      route_in       = route_ff;
      expired_in     = expired_ff;
      changed_in     = changed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_route_in   = rsp_route_ff;
      rsp_expired_in = rsp_expired_ff;
      rsp_was_ret_in = rsp_was_ret_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_cvalid_in  = rsp_cvalid_ff;
      rsp_caddr_in   = rsp_caddr_ff;
      rsp_cport_in   = rsp_cport_ff;
      rsp_count_in   = rsp_count_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = k_ff;
      ram_wr_data    = ram_rd_data;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = idx_ff[AW-1:0];
      req_ready      = 1'b0;

      unique case (state_ff)
         celr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in     = req_mode;
               src_addr_in = req_src_addr;
               src_port_in = req_src_port;
               now_in      = req_now_ms;
               idx_in      = '0;
               found_in    = 1'b0;
               route_in    = celr_pkg::ROUTE_IGNORE;
               expired_in  = 1'b0;
               changed_in  = 1'b0;
               state_in    = (req_mode == celr_pkg::MODE_TICK) ? celr_pkg::ST_DECIDE
                                                               : celr_pkg::ST_SEARCH;
            end
         end

         // one read issued per cycle; compare lands the cycle after
         celr_pkg::ST_SEARCH: begin
            if (entry_hit) begin
               found_in = 1'b1;
               k_in     = chk_idx_ff;
               state_in = celr_pkg::ST_DECIDE;
            end else if (idx_ff < used_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff[AW-1:0];
               chk_idx_in  = idx_ff[AW-1:0];
               idx_in      = idx_ff + CW'(1);
               pend_in     = 1'b1;
            end else begin
               state_in = celr_pkg::ST_DECIDE;
            end
         end

         celr_pkg::ST_DECIDE: begin
            state_in = celr_pkg::ST_RESP;
            if (mode_ff == celr_pkg::MODE_TICK) begin
               if (have_ff && state_expired) begin
                  have_in      = 1'b0;
                  cur_addr_in  = '0;
                  cur_port_in  = '0;
                  seen_ms_in   = '0;
                  used_in      = '0;
                  expired_in   = 1'b1;
               end
            end else if (from_target) begin
               route_in = have_ff ? celr_pkg::ROUTE_TO_CLIENT : celr_pkg::ROUTE_IGNORE;
            end else if (!have_ff) begin
               have_in      = 1'b1;
               cur_addr_in  = src_addr_ff;
               cur_port_in  = src_port_ff;
               seen_ms_in   = now_ff;
               route_in     = celr_pkg::ROUTE_TO_HOST;
               changed_in   = 1'b1;
            end else if (from_client) begin
               seen_ms_in   = now_ff;
               route_in     = celr_pkg::ROUTE_TO_HOST;
            end else if (found_ff && !rebind_ok) begin
               route_in = celr_pkg::ROUTE_IGNORE;
            end else begin
               // replace client; old one goes to the tail of the list
               old_in       = {cur_addr_ff, cur_port_ff};
               cur_addr_in  = src_addr_ff;
               cur_port_in  = src_port_ff;
               seen_ms_in   = now_ff;
               route_in     = celr_pkg::ROUTE_TO_HOST;
               changed_in   = 1'b1;
               if (found_ff) begin
                  state_in = celr_pkg::ST_SHIFT_RD;
               end else if (used_ff == CW'(RETIRED_DEPTH)) begin
                  k_in     = '0;
                  state_in = celr_pkg::ST_SHIFT_RD;
               end else begin
                  state_in = celr_pkg::ST_PUSH;
               end
            end
         end

         // close the gap at k: entry k+1 moves to k until the tail
         celr_pkg::ST_SHIFT_RD: begin
            if (k_next < used_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = k_next[AW-1:0];
               state_in    = celr_pkg::ST_SHIFT_WR;
            end else begin
               used_in  = used_ff - CW'(1);
               state_in = celr_pkg::ST_PUSH;
            end
         end

         celr_pkg::ST_SHIFT_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = k_ff;
            ram_wr_data = ram_rd_data;
            k_in        = k_next[AW-1:0];
            state_in    = celr_pkg::ST_SHIFT_RD;
         end

         celr_pkg::ST_PUSH: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = used_ff[AW-1:0];
            ram_wr_data = old_ff;
            used_in     = used_ff + CW'(1);
            state_in    = celr_pkg::ST_RESP;
         end

         celr_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_route_in   = route_ff;
               rsp_expired_in = expired_ff;
               rsp_was_ret_in = (mode_ff == celr_pkg::MODE_PACKET) && found_ff;
               rsp_changed_in = changed_ff;
               rsp_cvalid_in  = have_ff;
               rsp_caddr_in   = have_ff ? cur_addr_ff : '0;
               rsp_cport_in   = have_ff ? cur_port_ff : '0;
               rsp_count_in   = celr_pkg::COUNT_W'(used_ff);
               state_in       = celr_pkg::ST_IDLE;
            end
         end

         default: state_in = celr_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_route              = rsp_route_ff;
   assign rsp_expired            = rsp_expired_ff;
   assign rsp_from_retired       = rsp_was_ret_ff;
   assign rsp_client_changed     = rsp_changed_ff;
   assign rsp_client_valid       = rsp_cvalid_ff;
   assign rsp_client_addr        = rsp_caddr_ff;
   assign rsp_client_port        = rsp_cport_ff;
   assign rsp_retired_count      = rsp_count_ff;

endmodule

### tb/sv/client_endpoint_learning_router_test.sv
// ----------------------------------------------------------------------------
// client_endpoint_learning_router_test
// Self-checking bench for the endpoint learning router. A short directed run
// covers learning, refresh, replacement, rebind hold-off, expiry and time
// wrap. Random packet and tick traffic then runs under several register
// settings, with random stalls on both channels and one long result stall.
// Every result word is checked against an in-bench model of the client and
// the retired list.
// ----------------------------------------------------------------------------
module client_endpoint_learning_router_test;
   import celr_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 60;
   localparam int POOL_SIZE    = 24;    // more than the list depth, forces evictions

   typedef logic [ENDPOINT_W-1:0] endpoint_type;

   typedef struct packed {
      logic                mode;
      logic [ADDR_W-1:0]   src_addr;
      logic [PORT_W-1:0]   src_port;
      logic [TIME_W-1:0]   now_ms;
   } route_req_type;

   typedef struct packed {
      logic [ROUTE_W-1:0]  route;
      logic                expired;
      logic                from_retired;
      logic                client_changed;
      logic                client_valid;
      logic [ADDR_W-1:0]   client_addr;
      logic [PORT_W-1:0]   client_port;
      logic [COUNT_W-1:0]  retired_count;
   } route_rsp_type;

   class router_scoreboard;
      logic [ADDR_W-1:0]   target_addr;
      logic [PORT_W-1:0]   target_port;
      logic [REBIND_W-1:0] rebind_idle;
      logic [STATE_W-1:0]  state_idle;
      bit                  have_client;
      endpoint_type        client_ep;
      logic [TIME_W-1:0]   seen_ms;
      endpoint_type        retired_q[$];      // index 0 is the oldest
      route_rsp_type       expected_routes[$];
      int                  errors;

      function new();
         target_addr = '0;
         target_port = '0;
         rebind_idle = REBIND_RESET;
         state_idle  = STATE_RESET;
         have_client = 1'b0;
         client_ep   = '0;
         seen_ms     = '0;
         errors      = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [CSR_DW-1:0] value);
         case (idx)
            REG_TARGET_ADDR: target_addr = value;
            REG_TARGET_PORT: target_port = value[PORT_W-1:0];
            REG_REBIND_IDLE: rebind_idle = value[REBIND_W-1:0];
            REG_STATE_IDLE:  state_idle  = value[STATE_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_routes.size();
      endfunction

      function void note_request(route_req_type r);
         route_rsp_type     e;
         endpoint_type      src;
         logic [TIME_W-1:0] idle;
         int                pos;
         e    = '0;
         src  = {r.src_addr, r.src_port};
         idle = r.now_ms - seen_ms;
         pos  = -1;
         if (r.mode == MODE_TICK) begin
            if (have_client && idle >= TIME_W'(state_idle)) begin
               have_client = 1'b0;
               client_ep   = '0;
               seen_ms     = '0;
               retired_q.delete();
               e.expired   = 1'b1;
            end
         end else begin
            foreach (retired_q[i]) begin
               if (pos < 0 && retired_q[i] == src) pos = i;
            end
            e.from_retired = (pos >= 0);
            if (r.src_addr == target_addr && r.src_port == target_port) begin
               e.route = have_client ? ROUTE_TO_CLIENT : ROUTE_IGNORE;
            end else if (!have_client) begin
               have_client      = 1'b1;
               client_ep        = src;
               seen_ms          = r.now_ms;
               e.route          = ROUTE_TO_HOST;
               e.client_changed = 1'b1;
            end else if (src == client_ep) begin
               seen_ms   = r.now_ms;
               e.route   = ROUTE_TO_HOST;
            end else if (pos >= 0 && idle < TIME_W'(rebind_idle)) begin
               e.route = ROUTE_IGNORE;
            end else begin
               if (pos >= 0) retired_q.delete(pos);
               if (retired_q.size() >= DEFAULT_RETIRED_DEPTH) void'(retired_q.pop_front());
               retired_q = {retired_q, client_ep};
               client_ep        = src;
               seen_ms          = r.now_ms;
               e.route          = ROUTE_TO_HOST;
               e.client_changed = 1'b1;
            end
         end
         e.client_valid = have_client;
         {e.client_addr, e.client_port} = have_client ? client_ep : '0;
         e.retired_count = COUNT_W'(retired_q.size());
         expected_routes = {expected_routes, e};
      endfunction

      function void field_check(string name, logic [ENDPOINT_W-1:0] exp_v,
                                logic [ENDPOINT_W-1:0] got_v);
         if (got_v !== exp_v) begin
            errors++;
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
         end
      endfunction

      function void check_response(route_rsp_type got);
         route_rsp_type e;
         if (expected_routes.size() == 0) begin
            errors++;
            $error("result word with no expectation pending");
            return;
         end
         e = expected_routes.pop_front();
         field_check("route", ENDPOINT_W'(e.route), ENDPOINT_W'(got.route));
         field_check("expired", ENDPOINT_W'(e.expired), ENDPOINT_W'(got.expired));
         field_check("from_retired", ENDPOINT_W'(e.from_retired),
                     ENDPOINT_W'(got.from_retired));
         field_check("client_changed", ENDPOINT_W'(e.client_changed),
                     ENDPOINT_W'(got.client_changed));
         field_check("client_valid", ENDPOINT_W'(e.client_valid),
                     ENDPOINT_W'(got.client_valid));
         field_check("client_addr", ENDPOINT_W'(e.client_addr),
                     ENDPOINT_W'(got.client_addr));
         field_check("client_port", ENDPOINT_W'(e.client_port),
                     ENDPOINT_W'(got.client_port));
         field_check("retired_count", ENDPOINT_W'(e.retired_count),
                     ENDPOINT_W'(got.retired_count));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_mode = MODE_PACKET;
   logic [ADDR_W-1:0]   req_src_addr = '0;
   logic [PORT_W-1:0]   req_src_port = '0;
   logic [TIME_W-1:0]   req_now_ms = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [ROUTE_W-1:0]  rsp_route;
   logic                rsp_expired;
   logic                rsp_from_retired;
   logic                rsp_client_changed;
   logic                rsp_client_valid;
   logic [ADDR_W-1:0]   rsp_client_addr;
   logic [PORT_W-1:0]   rsp_client_port;
   logic [COUNT_W-1:0]  rsp_retired_count;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   router_scoreboard    sb;
   bit                  steady = 1'b0;     // no gaps on either side
   int                  hold_cycles = 0;   // long result stall, counted by the sink
   int                  cycle_count = 0;
   logic [TIME_W-1:0]   now_base = '0;
   endpoint_type        endpoint_pool[POOL_SIZE];

   client_endpoint_learning_router dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_mode               (req_mode),
      .req_src_addr           (req_src_addr),
      .req_src_port           (req_src_port),
      .req_now_ms             (req_now_ms),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_route              (rsp_route),
      .rsp_expired            (rsp_expired),
      .rsp_from_retired       (rsp_from_retired),
      .rsp_client_changed     (rsp_client_changed),
      .rsp_client_valid       (rsp_client_valid),
      .rsp_client_addr        (rsp_client_addr),
      .rsp_client_port        (rsp_client_port),
      .rsp_retired_count      (rsp_retired_count),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("client_endpoint_learning_router_test NOT OK");
         $finish;
      end
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic route_req_type item(logic mode, logic [ADDR_W-1:0] addr,
                                          logic [PORT_W-1:0] port, logic [TIME_W-1:0] t);
      route_req_type r;
      r.mode     = mode;
      r.src_addr = addr;
      r.src_port = port;
      r.now_ms   = t;
      return r;
   endfunction

   // Random word steered by the model state so that refreshes, retired hits
   // and idle thresholds come up often.
   function automatic route_req_type make_item();
      route_req_type r;
      endpoint_type  ep;
      int            pick;
      r.mode = ($urandom_range(0, 99) < 8) ? MODE_TICK : MODE_PACKET;
      pick = $urandom_range(0, 99);
      if (pick < 25 && sb.have_client)
         ep = sb.client_ep;
      else if (pick < 35)
         ep = {sb.target_addr, sb.target_port};
      else if (pick < 55 && sb.retired_q.size() > 0)
         ep = sb.retired_q[$urandom_range(0, sb.retired_q.size() - 1)];
      else if (pick < 92)
         ep = endpoint_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
         ep = {$urandom(), PORT_W'($urandom())};
      {r.src_addr, r.src_port} = ep;
      pick = $urandom_range(0, 99);
      if ((r.mode == MODE_TICK && pick < 40) || (pick >= 15 && pick < 22))
         now_base = TIME_W'(sb.seen_ms + TIME_W'(sb.state_idle)
                            + $urandom_range(0, 2) - 1);
      else if (pick < 15)
         now_base = TIME_W'(sb.seen_ms + TIME_W'(sb.rebind_idle)
                            + $urandom_range(0, 2) - 1);
      else if (pick < 27)
         now_base = $urandom();
      else
         now_base = now_base + $urandom_range(0, 40);
      r.now_ms = now_base;
      return r;
   endfunction

   task automatic send_item(route_req_type r);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_mode     <= r.mode;
      req_src_addr <= r.src_addr;
      req_src_port <= r.src_port;
      req_now_ms   <= r.now_ms;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(r);
   endtask

   task automatic stop_stream();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_access(input logic write_en, input logic [1:0] idx,
                             input logic [CSR_DW-1:0] wdata,
                             output logic [CSR_DW-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write_en;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_expect(logic [1:0] idx, logic [CSR_DW-1:0] exp_v);
      logic [CSR_DW-1:0] rd;
      csr_access(1'b0, idx, '0, rd);
      if (rd !== exp_v) begin
         sb.errors++;
         $error("register %0d: expected %0h, got %0h", idx, exp_v, rd);
      end
   endtask

   task automatic csr_set(logic [1:0] idx, logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] rd;
      csr_access(1'b1, idx, value, rd);
      sb.write_reg(idx, value);
      csr_expect(idx, value);
   endtask

   task automatic configure(logic [ADDR_W-1:0] t_addr, logic [PORT_W-1:0] t_port,
                            logic [REBIND_W-1:0] rebind, logic [STATE_W-1:0] state_ms);
      csr_set(REG_TARGET_ADDR, t_addr);
      csr_set(REG_TARGET_PORT, CSR_DW'(t_port));
      csr_set(REG_REBIND_IDLE, CSR_DW'(rebind));
      csr_set(REG_STATE_IDLE, CSR_DW'(state_ms));
   endtask

   initial begin : result_sink
      route_rsp_type got;
      int            stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = gap_len();
         end
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            got.route              = rsp_route;
            got.expired            = rsp_expired;
            got.from_retired       = rsp_from_retired;
            got.client_changed     = rsp_client_changed;
            got.client_valid       = rsp_client_valid;
            got.client_addr        = rsp_client_addr;
            got.client_port        = rsp_client_port;
            got.retired_count      = rsp_retired_count;
            sb.check_response(got);
         end
      end
   end

   initial begin : stimulus
      int ph;
      int n;
      int k;
      sb = new();
      for (k = 0; k < POOL_SIZE; k++) begin
         if (k < 8)
            endpoint_pool[k] = {$urandom(), PORT_W'($urandom())};
         else if (k < 16)   // same address, other port
            endpoint_pool[k] = {endpoint_pool[k-8][ENDPOINT_W-1:PORT_W], PORT_W'($urandom())};
         else               // same port, other address
            endpoint_pool[k] = {$urandom(), endpoint_pool[k-16][PORT_W-1:0]};
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_expect(REG_TARGET_ADDR, '0);
      csr_expect(REG_TARGET_PORT, '0);
      csr_expect(REG_REBIND_IDLE, CSR_DW'(REBIND_RESET));
      csr_expect(REG_STATE_IDLE, CSR_DW'(STATE_RESET));

      // reset settings: target 0:0, rebind 500, expiry 30000
      send_item(item(MODE_TICK, '1, '1, 32'd0));                 // tick, no client
      send_item(item(MODE_PACKET, '0, '0, 32'd10));              // target, no client
      send_item(item(MODE_PACKET, '1, '1, 32'd20));              // learn
      send_item(item(MODE_PACKET, '0, '0, 32'd30));              // host to client
      send_item(item(MODE_PACKET, '1, '1, 32'd40));              // refresh
      send_item(item(MODE_PACKET, 32'd1, 16'd1, 32'd50));        // replace
      send_item(item(MODE_PACKET, '1, '1, 32'd100));             // retired, held off
      send_item(item(MODE_PACKET, '1, '1, 32'd549));             // one short of rebind
      send_item(item(MODE_PACKET, '1, '1, 32'd550));             // rebind at threshold
      send_item(item(MODE_PACKET, 32'd1, 16'hFFFF, 32'd560));    // port differs only
      send_item(item(MODE_PACKET, '1, 16'd1, 32'd570));          // address differs only
      send_item(item(MODE_TICK, '0, '0, 32'd30569));             // one short of expiry
      send_item(item(MODE_TICK, '0, '0, 32'd30570));             // expires
      send_item(item(MODE_PACKET, 32'd1, 16'd1, 32'd600));       // learn after clear
      send_item(item(MODE_PACKET, 32'd1, 16'd1, 32'hFFFF_FFF0)); // refresh near wrap
      send_item(item(MODE_PACKET, 32'h1234_5678, 16'hABCD, 32'hFFFF_FFF8));
      send_item(item(MODE_PACKET, 32'd1, 16'd1, 32'h0000_01EB)); // held off across wrap
      send_item(item(MODE_PACKET, 32'd1, 16'd1, 32'h0000_01EC)); // rebind across wrap
      send_item(item(MODE_TICK, '1, '0, 32'h0000_01EC));         // zero idle

      for (ph = 0; ph < 5; ph++) begin
         stop_stream();
         wait_idle();
         n = 300;
         case (ph)
            0: configure($urandom(), PORT_W'($urandom()), 16'd500, 24'd30000);
            1: begin
               configure('1, '1, '0, '0);
               hold_cycles = 400;   // sink holds off while the source keeps offering
               n = 250;
            end
            2: begin
               configure('0, '0, '1, '1);
               now_base = 32'hFFFF_F000;
               n = 250;
            end
            3: begin
               configure($urandom(), PORT_W'($urandom()),
                         REBIND_W'($urandom_range(1, 100)), STATE_W'($urandom_range(50, 2000)));
               steady = 1'b1;
            end
            default: begin
               configure($urandom(), PORT_W'($urandom()), 16'd500, 24'd30000);
               steady = 1'b0;
               n = 500;
            end
         endcase
         for (k = 0; k < n; k++) send_item(make_item());
      end

      stop_stream();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("client_endpoint_learning_router_test OK");
      else
         $display("client_endpoint_learning_router_test NOT OK");
      $finish;
   end

endmodule
